// ===== rtl/gac_pkg.sv =====
// Shared types and constants of the Gram matrix accumulator.
// Used by gac_lane, gac_merge and gram_matrix_accumulator_unit; no dependencies.
package gac_pkg;

  localparam int FEAT_W    = 16;  // Q1.15 feature
  localparam int PROD_W    = 32;  // Q2.30 product
  localparam int OUT_SUM_W = 48;  // width of the emitted sum
  localparam int IDX_W     = 3;   // row and column index
  localparam int CNT_W     = 4;   // active feature count register
  localparam int TRI_W     = 6;   // number of entries in a readout, up to 36

  localparam logic [CNT_W-1:0] ACTIVE_RESET = 4'd8;

  typedef enum logic [1:0] {
    ST_ACC,    // take samples, accumulate
    ST_DRAIN,  // last sample in the product stage, snapshot the sums
    ST_READ    // shift the snapshot out, one entry per cycle
  } state_t;

  typedef struct packed {
    logic load;   // copy lane sums into the readout chain
    logic shift;  // emit the head entry and advance
  } merge_ctl_t;

  // Number of lower-triangle entries for n rows.
  function automatic logic [TRI_W-1:0] tri_count(input logic [CNT_W-1:0] n);
    logic [7:0] p;
    p = {4'd0, n} * ({4'd0, n} + 8'd1);
    return p[TRI_W:1];
  endfunction

endpackage

// ===== rtl/gac_lane.sv =====
// One accumulation lane: registered product of two features, then saturating add.
// Depends on gac_pkg.
module gac_lane import gac_pkg::*; #(
  parameter int ACC_BITS = 48
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       take,
  input  logic signed [FEAT_W-1:0]   a,
  input  logic signed [FEAT_W-1:0]   b,
  input  logic                       flush,
  output logic        [ACC_BITS-1:0] sum_next,
  output logic                       clip_next
);

  localparam logic [ACC_BITS-1:0] SUM_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
  localparam logic [ACC_BITS-1:0] SUM_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

  logic signed [PROD_W-1:0]   prod;
  logic                       take1;
  logic        [ACC_BITS-1:0] sum;
  logic                       clip;
  logic        [ACC_BITS:0]   wide;
  logic                       ovf;

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

  // Add with one guard bit; a mismatch of the top two bits is an overflow.
  always_comb begin
    wide = {sum[ACC_BITS-1], sum} + {{(ACC_BITS+1-PROD_W){prod[PROD_W-1]}}, prod};
    ovf  = wide[ACC_BITS] != wide[ACC_BITS-1];
    if (!take1) begin
      sum_next = sum;
    end else if (ovf) begin
      sum_next = wide[ACC_BITS] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_next = wide[ACC_BITS-1:0];
    end
    clip_next = clip | (take1 & ovf);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      take1 <= 1'b0;
      sum   <= '0;
      clip  <= 1'b0;
    end else begin
      take1 <= take;
      if (flush) begin
        sum  <= '0;
        clip <= 1'b0;
      end else begin
        sum  <= sum_next;
        clip <= clip_next;
      end
    end
  end

endmodule

// ===== rtl/gac_merge.sv =====
// Readout stage: snapshot of all lane sums, shifted out in row-major order.
// Depends on gac_pkg.
module gac_merge import gac_pkg::*; #(
  parameter int FEATURES = 8,
  parameter int ACC_BITS = 48
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  merge_ctl_t                           ctl,
  input  logic [FEATURES*(FEATURES+1)/2-1:0][ACC_BITS-1:0] sums_in,
  input  logic [FEATURES*(FEATURES+1)/2-1:0]   clips_in,
  input  logic [TRI_W-1:0]                     total,
  output logic                                 read_last,
  output logic [IDX_W-1:0]                     row_index,
  output logic [IDX_W-1:0]                     col_index,
  output logic signed [OUT_SUM_W-1:0]          pair_sum,
  output logic                                 saturated,
  output logic                                 last_entry,
  output logic                                 result_valid
);

  localparam int PAIRS = FEATURES * (FEATURES + 1) / 2;

  logic [PAIRS-1:0][ACC_BITS-1:0] chain;
  logic [PAIRS-1:0]               clip_chain;
  logic [TRI_W-1:0]               cnt;
  logic [TRI_W-1:0]               total_q;
  logic [IDX_W-1:0]               row;
  logic [IDX_W-1:0]               col;
  logic [OUT_SUM_W-1:0]           head_sum;

  assign read_last = cnt == total_q - TRI_W'(1);

  generate
    if (ACC_BITS >= OUT_SUM_W) begin : g_trunc
      assign head_sum = chain[0][OUT_SUM_W-1:0];
    end else begin : g_sext
      assign head_sum = {{(OUT_SUM_W-ACC_BITS){chain[0][ACC_BITS-1]}}, chain[0]};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      chain      <= sums_in;
      clip_chain <= clips_in;
      total_q    <= total;
    end else if (ctl.shift) begin
      chain      <= {{ACC_BITS{1'b0}}, chain[PAIRS-1:1]};
      clip_chain <= {1'b0, clip_chain[PAIRS-1:1]};
      pair_sum   <= head_sum;
      saturated  <= clip_chain[0];
      last_entry <= read_last;
      row_index  <= row;
      col_index  <= col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      cnt          <= '0;
      row          <= '0;
      col          <= '0;
    end else begin
      result_valid <= ctl.shift;
      if (ctl.load) begin
        cnt <= '0;
        row <= '0;
        col <= '0;
      end else if (ctl.shift) begin
        cnt <= cnt + TRI_W'(1);
        if (col == row) begin
          row <= row + IDX_W'(1);
          col <= '0;
        end else begin
          col <= col + IDX_W'(1);
        end
      end
    end
  end

endmodule

// ===== rtl/gram_matrix_accumulator_unit.sv =====
// Gram matrix accumulator: one lane per lower-triangle pair; active rows add each item.
// Throughput: one sample item per cycle while accumulating (busy low).
// After the last item, ST_DRAIN snapshots the sums and ST_READ shifts them out;
// results are registered, one per cycle, n(n+1)/2 in all (n: clamped active count).
// busy stays high through the snapshot and the readout; the receiver cannot stall.
// Reset (rst, synchronous): clears all sums and clip flags, active count to 8.
// Depends on gac_pkg, gac_lane and gac_merge.
module gram_matrix_accumulator_unit import gac_pkg::*; #(
  parameter int FEATURES = 8,
  parameter int ACC_BITS = 48
) (
  input  logic                        clk,
  input  logic                        rst,
  // sample item channel
  input  logic                        start,
  output logic                        busy,
  input  logic signed [FEAT_W-1:0]    feature_0,
  input  logic signed [FEAT_W-1:0]    feature_1,
  input  logic signed [FEAT_W-1:0]    feature_2,
  input  logic signed [FEAT_W-1:0]    feature_3,
  input  logic signed [FEAT_W-1:0]    feature_4,
  input  logic signed [FEAT_W-1:0]    feature_5,
  input  logic signed [FEAT_W-1:0]    feature_6,
  input  logic signed [FEAT_W-1:0]    feature_7,
  input  logic                        last_sample,
  // configuration channel: active feature count
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CNT_W-1:0]            cfg_data,
  // result strobe and payload
  output logic                        result_valid,
  output logic [IDX_W-1:0]            row_index,
  output logic [IDX_W-1:0]            col_index,
  output logic signed [OUT_SUM_W-1:0] pair_sum,
  output logic                        saturated,
  output logic                        last_entry
);

  localparam int PAIRS = FEATURES * (FEATURES + 1) / 2;

  state_t                         state;
  state_t                         state_next;
  merge_ctl_t                     ctl;
  logic [CNT_W-1:0]               active_features;
  logic [CNT_W-1:0]               n_eff;
  logic                           accept;
  logic                           read_last;
  logic signed [FEAT_W-1:0]       feat [8];
  logic [PAIRS-1:0][ACC_BITS-1:0] lane_sum;
  logic [PAIRS-1:0]               lane_clip;

  assign feat[0] = feature_0;
  assign feat[1] = feature_1;
  assign feat[2] = feature_2;
  assign feat[3] = feature_3;
  assign feat[4] = feature_4;
  assign feat[5] = feature_5;
  assign feat[6] = feature_6;
  assign feat[7] = feature_7;

  assign accept    = start && !busy;
  assign cfg_ready = !busy;

  // Clamp the count: zero acts as one, anything above FEATURES as FEATURES.
  always_comb begin
    priority if (active_features == '0) begin
      n_eff = CNT_W'(1);
    end else if (active_features > CNT_W'(FEATURES)) begin
      n_eff = CNT_W'(FEATURES);
    end else begin
      n_eff = active_features;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_features <= ACTIVE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      active_features <= cfg_data;
    end
  end

  // Sequencer: accumulate until the last item, let its products land, then drain.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_ACC:   if (accept && last_sample) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_READ;
      ST_READ:  if (read_last) state_next = ST_ACC;
      default:  state_next = ST_ACC;
    endcase
  end

  always_comb begin
    busy      = state != ST_ACC;
    ctl.load  = state == ST_DRAIN;
    ctl.shift = state == ST_READ;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACC;
    end else begin
      state <= state_next;
    end
  end

  // One lane per pair (i, j), j <= i, placed in readout order.
  // Rows at or beyond the active count hold still.
  generate
    for (genvar I = 0; I < FEATURES; I++) begin : g_row
      for (genvar J = 0; J <= I; J++) begin : g_col
        localparam int P = I * (I + 1) / 2 + J;
        gac_lane #(
          .ACC_BITS (ACC_BITS)
        ) u_lane (
          .clk       (clk),
          .rst       (rst),
          .take      (accept && (CNT_W'(I) < n_eff)),
          .a         (feat[I]),
          .b         (feat[J]),
          .flush     (ctl.load),
          .sum_next  (lane_sum[P]),
          .clip_next (lane_clip[P])
        );
      end
    end
  endgenerate

  // The snapshot takes the sums with the last item already added;
  // the lanes clear on the same edge.
  gac_merge #(
    .FEATURES (FEATURES),
    .ACC_BITS (ACC_BITS)
  ) u_merge (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .sums_in      (lane_sum),
    .clips_in     (lane_clip),
    .total        (tri_count(n_eff)),
    .read_last    (read_last),
    .row_index    (row_index),
    .col_index    (col_index),
    .pair_sum     (pair_sum),
    .saturated    (saturated),
    .last_entry   (last_entry),
    .result_valid (result_valid)
  );

  a_result_only_in_read : assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state == ST_READ))
    else $error("result strobe outside readout");

  a_last_flag_with_strobe : assert property (@(posedge clk) disable iff (rst)
    last_entry && result_valid |=> !result_valid)
    else $error("result strobe after the final entry");

  a_last_item_locks : assert property (@(posedge clk) disable iff (rst)
    accept && last_sample |=> busy && state == ST_DRAIN)
    else $error("last item did not start the readout");

  a_drain_one_cycle : assert property (@(posedge clk) disable iff (rst)
    state == ST_DRAIN |=> state == ST_READ)
    else $error("snapshot stage did not advance to readout");

endmodule
